// ===== rtl/zled_pkg.sv =====
// shared types and constants of the archive entry deframer
package zled_pkg;

  localparam int unsigned SigLen = 4;
  localparam int unsigned HeaderLen = 26;
  localparam int unsigned DescLen = 12;

  localparam logic [7:0] SIG_P = 8'h50;
  localparam logic [7:0] SIG_K = 8'h4b;

  // signature bytes, index 0 first on the wire
  localparam logic [SigLen-1:0][7:0] HDR_SIG = {8'h04, 8'h03, SIG_K, SIG_P};
  localparam logic [SigLen-1:0][7:0] DESC_SIG = {8'h08, 8'h07, SIG_K, SIG_P};

  // byte kind codes
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_NAME = 3'd1;
  localparam logic [2:0] KIND_EXTRA = 3'd2;
  localparam logic [2:0] KIND_DATA = 3'd3;
  localparam logic [2:0] KIND_DESC = 3'd4;

  typedef struct packed {
    logic [15:0] method;
    logic [15:0] flags;
    logic [31:0] crc;
    logic [31:0] csize;
    logic [31:0] size;
    logic [15:0] name_len;
    logic [15:0] extra_len;
  } summary_t;

  // all results caused by one input word
  typedef struct packed {
    logic [2:0] cnt;
    logic [SigLen-1:0][7:0] bytes;
    logic [2:0] kind;
    logic done;
    summary_t info;
  } group_t;

endpackage

// ===== rtl/zled_ifs.sv =====
// stream channel interfaces: raw archive words and tagged result words
interface zled_raw_if;
  logic valid;
  logic ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
  modport mon (input valid, input in_byte, input ready);
endinterface

interface zled_res_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic [2:0] byte_kind;
  logic last_of_run;
  logic file_done;
  logic [15:0] compression_method;
  logic [15:0] flag_bits;
  logic [31:0] crc_value;
  logic [31:0] compressed_size;
  logic [31:0] plain_size;
  logic [15:0] name_length;
  logic [15:0] extra_length;

  modport source (output valid, output out_byte, output byte_kind, output last_of_run,
                  output file_done, output compression_method, output flag_bits,
                  output crc_value, output compressed_size, output plain_size,
                  output name_length, output extra_length, input ready);
  modport sink (input valid, input out_byte, input byte_kind, input last_of_run,
                input file_done, input compression_method, input flag_bits,
                input crc_value, input compressed_size, input plain_size,
                input name_length, input extra_length, output ready);
  modport mon (input valid, input out_byte, input byte_kind, input last_of_run,
               input file_done, input compression_method, input flag_bits,
               input crc_value, input compressed_size, input plain_size,
               input name_length, input extra_length, input ready);
endinterface

// ===== rtl/zled_parser.sv =====
// input register, parse state and per-word result group generation
module zled_parser (
  input  logic clk,
  input  logic rst,
  zled_raw_if.sink raw,
  output logic grp_valid,
  output zled_pkg::group_t grp,
  input  logic grp_ready
);
  import zled_pkg::*;

  typedef enum logic [2:0] {
    MODE_HUNT    = 3'd0,
    MODE_HEADER  = 3'd1,
    MODE_NAME    = 3'd2,
    MODE_EXTRA   = 3'd3,
    MODE_SIZED   = 3'd4,
    MODE_UNSIZED = 3'd5,
    MODE_DESC    = 3'd6
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic [31:0] left;
    logic done;
  } run_t;

  // next run after the header or after a finished name or extra run
  function automatic run_t pick_run(mode_t from, logic [15:0] nl, logic [15:0] el,
                                    logic flag3, logic [31:0] cs);
    run_t r;
    r.mode = MODE_HUNT;
    r.left = '0;
    r.done = 1'b0;
    if (from == MODE_HEADER && nl != '0) begin
      r.mode = MODE_NAME;
      r.left = {16'd0, nl};
    end else if ((from == MODE_HEADER || from == MODE_NAME) && el != '0) begin
      r.mode = MODE_EXTRA;
      r.left = {16'd0, el};
    end else if (flag3) begin
      r.mode = MODE_UNSIZED;
    end else if (cs != '0) begin
      r.mode = MODE_SIZED;
      r.left = cs;
    end else begin
      r.done = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [31:0] set_byte(logic [31:0] w, logic [1:0] idx, logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[idx*8 +: 8] = b;
    return r;
  endfunction

  logic a_valid;
  logic [7:0] a_byte;
  logic a_fire;

  mode_t mode, mode_next;
  logic [1:0] mc, mc_next;
  logic [4:0] fc, fc_next;
  logic [31:0] left, left_next, left_dec;
  logic [15:0] flags, flags_next, method, method_next, nlen, nlen_next, elen, elen_next;
  logic [31:0] crc, crc_next, csize, csize_next, size, size_next;
  logic [4:0] off;
  logic done;
  run_t run;
  logic [2:0] cnt;
  logic [2:0] kind;
  logic [SigLen-1:0][7:0] sig_bytes;

  always_comb begin
    mode_next = mode;
    mc_next = mc;
    fc_next = fc;
    left_next = left;
    flags_next = flags;
    method_next = method;
    nlen_next = nlen;
    elen_next = elen;
    crc_next = crc;
    csize_next = csize;
    size_next = size;
    done = 1'b0;
    cnt = 3'd0;
    kind = KIND_HEADER;
    off = 5'd0;
    run = '{mode: MODE_HUNT, left: '0, done: 1'b0};
    left_dec = (left != '0) ? left - 32'd1 : left;
    sig_bytes = HDR_SIG;

    unique case (mode)
      MODE_HEADER: begin
        cnt = 3'd1;
        sig_bytes[0] = a_byte;
        // two-byte fields start on an even offset, so bit 0 picks the byte
        case (fc) inside
          5'd2, 5'd3: flags_next[{fc[0], 3'b000} +: 8] = a_byte;
          5'd4, 5'd5: method_next[{fc[0], 3'b000} +: 8] = a_byte;
          [5'd10:5'd13]: begin
            off = fc - 5'd10;
            crc_next = set_byte(crc, off[1:0], a_byte);
          end
          [5'd14:5'd17]: begin
            off = fc - 5'd14;
            csize_next = set_byte(csize, off[1:0], a_byte);
          end
          [5'd18:5'd21]: begin
            off = fc - 5'd18;
            size_next = set_byte(size, off[1:0], a_byte);
          end
          5'd22, 5'd23: nlen_next[{fc[0], 3'b000} +: 8] = a_byte;
          5'd24, 5'd25: elen_next[{fc[0], 3'b000} +: 8] = a_byte;
          default: ;
        endcase
        if (fc >= 5'(HeaderLen - 1)) begin
          fc_next = 5'd0;
          run = pick_run(MODE_HEADER, nlen_next, elen_next, flags_next[3], csize_next);
          mode_next = run.mode;
          left_next = run.left;
          mc_next = 2'd0;
          done = run.done;
        end else begin
          fc_next = fc + 5'd1;
        end
      end
      MODE_NAME, MODE_EXTRA, MODE_SIZED: begin
        cnt = 3'd1;
        sig_bytes[0] = a_byte;
        kind = (mode == MODE_NAME) ? KIND_NAME :
               (mode == MODE_EXTRA) ? KIND_EXTRA : KIND_DATA;
        left_next = left_dec;
        if (left_dec == '0) begin
          if (mode == MODE_SIZED) begin
            done = 1'b1;
          end else begin
            run = pick_run(mode, nlen, elen, flags[3], csize);
            mode_next = run.mode;
            left_next = run.left;
            mc_next = 2'd0;
            done = run.done;
          end
        end
      end
      MODE_UNSIZED: begin
        // held bytes are always the matched prefix of the descriptor signature
        sig_bytes = DESC_SIG;
        sig_bytes[mc] = a_byte;
        kind = KIND_DATA;
        if (a_byte == DESC_SIG[mc]) begin
          if (mc == 2'(SigLen - 1)) begin
            cnt = 3'(SigLen);
            kind = KIND_DESC;
            mc_next = 2'd0;
            fc_next = 5'd0;
            mode_next = MODE_DESC;
          end else begin
            mc_next = mc + 2'd1;
          end
        end else if (a_byte == SIG_P) begin
          cnt = {1'b0, mc};
          mc_next = 2'd1;
        end else begin
          cnt = {1'b0, mc} + 3'd1;
          mc_next = 2'd0;
        end
      end
      MODE_DESC: begin
        cnt = 3'd1;
        sig_bytes[0] = a_byte;
        kind = KIND_DESC;
        if (fc <= 5'd3) begin
          crc_next = set_byte(crc, fc[1:0], a_byte);
        end else if (fc <= 5'd7) begin
          csize_next = set_byte(csize, fc[1:0], a_byte);
        end else begin
          size_next = set_byte(size, fc[1:0], a_byte);
        end
        if (fc >= 5'(DescLen - 1)) begin
          fc_next = 5'd0;
          done = 1'b1;
        end else begin
          fc_next = fc + 5'd1;
        end
      end
      default: begin
        // hunting, and any unused mode code
        if (a_byte == HDR_SIG[mc]) begin
          if (mc == 2'(SigLen - 1)) begin
            cnt = 3'(SigLen);
            mc_next = 2'd0;
            fc_next = 5'd0;
            mode_next = MODE_HEADER;
          end else begin
            mc_next = mc + 2'd1;
          end
        end else begin
          mc_next = (a_byte == SIG_P) ? 2'd1 : 2'd0;
        end
      end
    endcase

    if (done) begin
      mode_next = MODE_HUNT;
      mc_next = 2'd0;
      fc_next = 5'd0;
      left_next = '0;
    end
  end

  assign grp_valid = a_valid && (cnt != 3'd0);
  assign a_fire = a_valid && (grp_ready || cnt == 3'd0);
  assign raw.ready = !a_valid || a_fire;

  always_comb begin
    grp.cnt = cnt;
    grp.bytes = sig_bytes;
    grp.kind = kind;
    grp.done = done;
    grp.info.method = method_next;
    grp.info.flags = flags_next;
    grp.info.crc = crc_next;
    grp.info.csize = csize_next;
    grp.info.size = size_next;
    grp.info.name_len = nlen_next;
    grp.info.extra_len = elen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      mode <= MODE_HUNT;
      mc <= 2'd0;
      fc <= 5'd0;
      left <= '0;
      flags <= '0;
      method <= '0;
      nlen <= '0;
      elen <= '0;
      crc <= '0;
      csize <= '0;
      size <= '0;
    end else begin
      if (raw.valid && raw.ready) begin
        a_valid <= 1'b1;
      end else if (a_fire) begin
        a_valid <= 1'b0;
      end
      if (a_fire) begin
        mode <= mode_next;
        mc <= mc_next;
        fc <= fc_next;
        left <= left_next;
        flags <= flags_next;
        method <= method_next;
        nlen <= nlen_next;
        elen <= elen_next;
        crc <= crc_next;
        csize <= csize_next;
        size <= size_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (raw.valid && raw.ready) begin
      a_byte <= raw.in_byte;
    end
  end

endmodule

// ===== rtl/zled_emitter.sv =====
// result group register and word-by-word output serializer
module zled_emitter (
  input  logic clk,
  input  logic rst,
  input  logic grp_valid,
  input  zled_pkg::group_t grp,
  output logic grp_ready,
  zled_res_if.source res
);
  import zled_pkg::*;

  logic g_valid;
  group_t g;
  logic [1:0] idx;
  logic last;
  logic fire;
  logic show;

  assign last = ({1'b0, idx} == g.cnt - 3'd1);
  assign fire = g_valid && res.ready;
  assign grp_ready = !g_valid || (res.ready && last);
  assign show = last && g.done;

  assign res.valid = g_valid;
  assign res.out_byte = g.bytes[idx];
  assign res.byte_kind = g.kind;
  assign res.last_of_run = last;
  assign res.file_done = show;
  assign res.compression_method = show ? g.info.method : '0;
  assign res.flag_bits = show ? g.info.flags : '0;
  assign res.crc_value = show ? g.info.crc : '0;
  assign res.compressed_size = show ? g.info.csize : '0;
  assign res.plain_size = show ? g.info.size : '0;
  assign res.name_length = show ? g.info.name_len : '0;
  assign res.extra_length = show ? g.info.extra_len : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
      idx <= 2'd0;
    end else if (grp_valid && grp_ready) begin
      g_valid <= 1'b1;
      idx <= 2'd0;
    end else if (fire && last) begin
      g_valid <= 1'b0;
      idx <= 2'd0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_valid && grp_ready) begin
      g <= grp;
    end
  end

endmodule

// ===== rtl/zip_local_entry_deframer_top.sv =====
// a word is registered at the parser input, and its results are registered again in the emitter
// throughput: one input word per cycle while each word gives at most one result and the
// result stream is ready; a word with n results (up to four) holds the emitter until all
// n have left, so a following word with results of its own holds the input until then
// reset: synchronous active-high rst empties both stages and returns to hunting
// the parse fields (flags, sizes, lengths) come out of reset as zero
module zip_local_entry_deframer_top (
  input logic clk,
  input logic rst,
  zled_raw_if.sink raw,
  zled_res_if.source marked
);
  import zled_pkg::*;

  // parser to emitter: one group of results per input word that yields any
  logic grp_valid;
  logic grp_ready;
  group_t grp;

  // stage one: input register, signature hunt, header capture and run tagging
  zled_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .raw       (raw),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_ready (grp_ready)
  );

  // stage two: holds the group and hands out its words one per cycle while the result
  // stream is ready, taking the next group on the same edge the last word leaves
  zled_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_ready (grp_ready),
    .res       (marked)
  );

endmodule

// ===== rtl/zled_checker.sv =====
// port-level checks of the deframer result stream, bound to the top level
module zled_checker (
  input logic clk,
  input logic rst,
  input logic valid,
  input logic ready,
  input logic [7:0] out_byte,
  input logic [2:0] byte_kind,
  input logic last_of_run,
  input logic file_done,
  input logic [15:0] compression_method,
  input logic [15:0] flag_bits,
  input logic [31:0] crc_value,
  input logic [31:0] compressed_size,
  input logic [31:0] plain_size,
  input logic [15:0] name_length,
  input logic [15:0] extra_length
);
  import zled_pkg::*;

  // entry summary rides only on the final word of a run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    valid && file_done |-> last_of_run)
    else $error("file_done without last_of_run");

  // summary fields stay zero away from an entry end
  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !file_done |->
      compression_method == '0 && flag_bits == '0 &&
      crc_value == '0 && compressed_size == '0 &&
      plain_size == '0 && name_length == '0 &&
      extra_length == '0)
    else $error("summary fields set without file_done");

  // a stalled result word keeps its byte and tag
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=>
      valid && $stable(out_byte) && $stable(byte_kind))
    else $error("stalled result word changed");

  // no tag code beyond the descriptor kind
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> byte_kind <= KIND_DESC)
    else $error("byte_kind out of range");

endmodule

bind zip_local_entry_deframer_top zled_checker u_zled_checker (
  .clk                (clk),
  .rst                (rst),
  .valid              (marked.valid),
  .ready              (marked.ready),
  .out_byte           (marked.out_byte),
  .byte_kind          (marked.byte_kind),
  .last_of_run        (marked.last_of_run),
  .file_done          (marked.file_done),
  .compression_method (marked.compression_method),
  .flag_bits          (marked.flag_bits),
  .crc_value          (marked.crc_value),
  .compressed_size    (marked.compressed_size),
  .plain_size         (marked.plain_size),
  .name_length        (marked.name_length),
  .extra_length       (marked.extra_length)
);
